[design/hmf_pkg.sv]
// shared widths, constants and helper functions of the histogram median filter
package hmf_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int MaxKernel = 7;
  localparam int StoreRows = MaxKernel + 1;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int SlotW     = $clog2(StoreRows);
  localparam int AddrW     = SlotW + ColW;
  localparam int PixW      = 8;
  localparam int WidthW    = 11;
  localparam int HeightW   = 13;
  localparam int KernW     = 3;
  localparam int CountW    = 6;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegKernel = 2'd2;

  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  // half the window, rounded down
  function automatic logic [CountW-1:0] median_limit(input logic [KernW-1:0] k);
    logic [CountW-1:0] r;
    case (k)
      3'd3:    r = 6'd4;
      3'd5:    r = 6'd12;
      3'd7:    r = 6'd24;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // reflect a coordinate into 0..n-1, edge pixel repeated
  function automatic logic [HeightW-1:0] mirror(input logic signed [15:0] p,
                                                input logic [HeightW-1:0] n);
    logic signed [15:0] q;
    logic signed [15:0] nn;
    q  = p;
    nn = $signed({3'b000, n});
    for (int i = 0; i < 4; i++) begin
      if (q < 16'sd0) begin
        q = ~q;
      end else if (q >= nn) begin
        q = (nn <<< 1) - q - 16'sd1;
      end
    end
    if (n <= 13'd1) begin
      return '0;
    end
    return q[HeightW-1:0];
  endfunction

endpackage

[design/hmf_line_store.sv]
// line store ram: one write port, one registered read port
module hmf_line_store
  import hmf_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [PixW-1:0]  wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [PixW-1:0]  rdata
);

  logic [PixW-1:0] mem [StoreRows*MaxWidth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/histogram_median_filter.sv]
// top level of the window median filter for 8-bit grey frames
// Pixels enter in raster order on the s_ side; each word gives at most one median word on the
// m_ side, in raster order, as soon as the window rows it needs are stored (mirrored borders).
// The median for kernel side k is found bit by bit from the top, and each bit sweeps the
// whole window through the single read port of the line store with one shared compare and
// counter, so the block takes no new word until the median is emitted. Flush words (tuser 1)
// drain the last rows. An invalid kernel side answers every word with tuser 1 and data 0.
// Any register write restarts the frame.
module histogram_median_filter
  import hmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // pixel
  input  logic                s_tuser,   // opcode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // median_value
  output logic                m_tlast,   // last_of_frame
  output logic                m_tuser,   // bad_setting
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [HeightW-1:0]  cfg_data
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StTally = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]         state;
  logic [WidthW-1:0]  width_reg;
  logic [HeightW-1:0] height_reg;
  logic [KernW-1:0]   ksize;
  logic [RowW-1:0]    in_row, out_row;
  logic [ColW-1:0]    in_col, out_col;
  logic               in_done;
  logic [2:0]         bit_idx;
  logic [PixW-1:0]    ans;
  logic [CountW-1:0]  cnt;
  logic [KernW-1:0]   wr_i, wc_i;
  logic               pend;
  logic               emit_bad;

  logic [WidthW-1:0]  eff_w;
  logic [HeightW-1:0] eff_h;
  logic [1:0]         half;
  logic               kernel_ok;
  logic [HeightW-1:0] lr;
  logic [WidthW-1:0]  lc;
  logic               win_ready;
  logic [PixW-1:0]    trial;
  logic               hit;
  logic [CountW-1:0]  total;
  logic signed [15:0] pr, pc;
  logic [HeightW-1:0] rr, cc;
  logic               we;
  logic [AddrW-1:0]   raddr;
  logic [PixW-1:0]    rdata;
  logic               accept;
  logic               out_free;

  always_comb begin
    if (width_reg == '0) begin
      eff_w = 11'd1;
    end else if (width_reg > 11'(MaxWidth)) begin
      eff_w = 11'(MaxWidth);
    end else begin
      eff_w = width_reg;
    end
    if (height_reg == '0) begin
      eff_h = 13'd1;
    end else if (height_reg > 13'(MaxHeight)) begin
      eff_h = 13'(MaxHeight);
    end else begin
      eff_h = height_reg;
    end
  end

  assign half      = ksize[2:1];
  assign kernel_ok = ksize[0] && (ksize >= 3'd3);

  always_comb begin
    lr = {1'b0, out_row} + {11'd0, half};
    if (lr > eff_h - 13'd1) begin
      lr = eff_h - 13'd1;
    end
    lc = {1'b0, out_col} + {9'd0, half};
    if (lc > eff_w - 11'd1) begin
      lc = eff_w - 11'd1;
    end
    win_ready = in_done || (lr < {1'b0, in_row}) ||
                ((lr == {1'b0, in_row}) && (lc < {1'b0, in_col}));
  end

  // window position of the sample being fetched
  assign pr    = $signed({4'd0, out_row}) + $signed({13'd0, wr_i}) - $signed({14'd0, half});
  assign pc    = $signed({6'd0, out_col}) + $signed({13'd0, wc_i}) - $signed({14'd0, half});
  assign rr    = mirror(pr, eff_h);
  assign cc    = mirror(pc, {2'b00, eff_w});
  assign raddr = {rr[SlotW-1:0], cc[ColW-1:0]};

  assign trial = ans | ((8'd1 << bit_idx) - 8'd1);
  assign hit   = pend && (rdata <= trial);
  assign total = cnt + {5'd0, hit};

  assign s_tready = (state == StIdle);
  assign accept   = s_tvalid && s_tready;
  assign we       = accept && kernel_ok && (s_tuser == OpPixel) && !in_done;
  assign out_free = !m_tvalid || m_tready;

  hmf_line_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr ({in_row[SlotW-1:0], in_col}),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      width_reg  <= 11'd640;
      height_reg <= 13'd480;
      ksize      <= 3'd3;
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      in_done    <= 1'b0;
      pend       <= 1'b0;
      emit_bad   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (accept) begin
            if (!kernel_ok) begin
              emit_bad <= 1'b1;
              state    <= StEmit;
            end else begin
              emit_bad <= 1'b0;
              state    <= StCheck;
              if (we) begin
                if ({1'b0, in_col} + 11'd1 >= eff_w) begin
                  in_col <= '0;
                  if ({1'b0, in_row} + 13'd1 >= eff_h) begin
                    in_row  <= '0;
                    in_done <= 1'b1;
                  end else begin
                    in_row <= in_row + 12'd1;
                  end
                end else begin
                  in_col <= in_col + 10'd1;
                end
              end
            end
          end
        end
        StCheck: begin
          bit_idx <= 3'd7;
          ans     <= '0;
          cnt     <= '0;
          wr_i    <= '0;
          wc_i    <= '0;
          pend    <= 1'b0;
          state   <= win_ready ? StScan : StIdle;
        end
        StScan: begin
          cnt  <= total;
          pend <= 1'b1;
          if (wc_i == ksize - 3'd1) begin
            wc_i <= '0;
            if (wr_i == ksize - 3'd1) begin
              wr_i  <= '0;
              state <= StTally;
            end else begin
              wr_i <= wr_i + 3'd1;
            end
          end else begin
            wc_i <= wc_i + 3'd1;
          end
        end
        StTally: begin
          pend <= 1'b0;
          cnt  <= '0;
          if (total <= median_limit(ksize)) begin
            ans <= ans | (8'd1 << bit_idx);
          end
          if (bit_idx == 3'd0) begin
            state <= StEmit;
          end else begin
            bit_idx <= bit_idx - 3'd1;
            state   <= StScan;
          end
        end
        StEmit: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= StIdle;
            if (emit_bad) begin
              m_tdata <= '0;
              m_tlast <= 1'b0;
              m_tuser <= 1'b1;
            end else begin
              m_tdata <= ans;
              m_tuser <= 1'b0;
              m_tlast <= ({1'b0, out_row} == eff_h - 13'd1) &&
                         ({1'b0, out_col} == eff_w - 11'd1);
              if ({1'b0, out_col} + 11'd1 >= eff_w) begin
                out_col <= '0;
                if ({1'b0, out_row} + 13'd1 >= eff_h) begin
                  out_row <= '0;
                  in_done <= 1'b0;
                end else begin
                  out_row <= out_row + 12'd1;
                end
              end else begin
                out_col <= out_col + 10'd1;
              end
            end
          end
        end
        default: state <= StIdle;
      endcase
      // register writes restart the frame
      if (cfg_we && (cfg_index == RegWidth || cfg_index == RegHeight ||
                     cfg_index == RegKernel)) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        in_done <= 1'b0;
        case (cfg_index)
          RegWidth:  width_reg  <= cfg_data[WidthW-1:0];
          RegHeight: height_reg <= cfg_data;
          default:   ksize      <= cfg_data[KernW-1:0];
        endcase
      end
    end
  end

endmodule
